### hdl/mwf_pkg.sv
// Shared types, constants and helpers for the median window filter.
`default_nettype none

package mwf_pkg;

    localparam int DEF_MAX_WIDTH        = 1024;
    localparam int DEF_MAX_HEIGHT       = 1024;
    localparam int DEF_MAX_WINDOW_CELLS = 25;

    localparam int PIX_W       = 8;
    localparam int WIN_SIDE    = 5;
    localparam int WIN_CELLS   = WIN_SIDE * WIN_SIDE;
    localparam int MEDIAN_RANK = WIN_CELLS / 2;
    localparam int RANK_W      = 5;
    localparam int LANES       = 8;
    localparam int LANE_W      = 3;
    localparam int POS_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int M_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [WIN_SIDE-1:0] col_t;
    typedef pix_t [WIN_CELLS-1:0] cells_t;

    typedef struct packed {
        logic [LANE_W-1:0]   base_lane;
        logic [WIN_SIDE-1:0] row_ok;
        pix_t                pix;
    } fetch_ctl_t;

    typedef struct packed {
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } out_meta_t;

    // Filler for cells outside the active window: half low, half high keeps the median.
    function automatic pix_t pad_value(input int d, input int k);
        int sum;
        sum = d + k;
        return sum[0] ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
    endfunction

endpackage

`default_nettype wire

### hdl/mwf_line_mem.sv
// Line store: eight row lanes per column address, column fetch with forwarding.
`default_nettype none

module mwf_line_mem
    import mwf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [LANE_W-1:0]            wr_lane,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  wire pix_t                         wr_pix,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  wire fetch_ctl_t                   rd_ctl,
    output col_t                              rd_col
);

    logic [LANES*PIX_W-1:0] mem [MAX_WIDTH];
    logic [LANES*PIX_W-1:0] rd_word_reg;
    fetch_ctl_t             rd_ctl_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr][wr_lane*PIX_W +: PIX_W] <= wr_pix;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
            rd_ctl_reg  <= rd_ctl;
        end
    end

    // Bottom row is the pixel written in the same transaction.
    always_comb begin
        logic [LANE_W-1:0] lane;
        for (int k = 0; k < WIN_SIDE; k++) begin
            lane = rd_ctl_reg.base_lane + LANE_W'(k);
            if (!rd_ctl_reg.row_ok[k]) begin
                rd_col[k] = '0;
            end else if (k == WIN_SIDE - 1) begin
                rd_col[k] = rd_ctl_reg.pix;
            end else begin
                rd_col[k] = rd_word_reg[lane*PIX_W +: PIX_W];
            end
        end
    end

endmodule

`default_nettype wire

### hdl/mwf_rank_median.sv
// Pipelined rank selector: picks the middle element of the 25 window cells.
`default_nettype none

module mwf_rank_median
    import mwf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire cells_t    in_cells,
    input  wire out_meta_t in_meta,
    output logic           out_valid,
    output pix_t           out_median,
    output out_meta_t      out_meta
);

    logic                 c_valid_reg, d_valid_reg, e_valid_reg, o_valid_reg;
    cells_t               c_cells_reg, d_cells_reg, e_cells_reg;
    out_meta_t            c_meta_reg, d_meta_reg, e_meta_reg, o_meta_reg;
    logic [WIN_CELLS-1:0] d_beats_reg [WIN_CELLS];
    logic [WIN_CELLS-1:0] beats_next [WIN_CELLS];
    logic [RANK_W-1:0]    e_rank_reg [WIN_CELLS];
    logic [RANK_W-1:0]    rank_next [WIN_CELLS];
    logic [WIN_CELLS-1:0] hit;
    pix_t                 median_next;
    pix_t                 o_median_reg;

    // Ties break by cell index so every rank is unique.
    always_comb begin
        for (int i = 0; i < WIN_CELLS; i++) begin
            for (int j = 0; j < WIN_CELLS; j++) begin
                beats_next[i][j] = (c_cells_reg[j] < c_cells_reg[i]) ||
                                   ((c_cells_reg[j] == c_cells_reg[i]) && (j < i));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WIN_CELLS; i++) begin
            rank_next[i] = '0;
            for (int j = 0; j < WIN_CELLS; j++) begin
                rank_next[i] = rank_next[i] + RANK_W'(d_beats_reg[i][j]);
            end
        end
    end

    always_comb begin
        median_next = '0;
        for (int i = 0; i < WIN_CELLS; i++) begin
            hit[i] = (e_rank_reg[i] == RANK_W'(MEDIAN_RANK));
            if (hit[i]) begin
                median_next = median_next | e_cells_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= in_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            o_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_cells_reg  <= in_cells;
            c_meta_reg   <= in_meta;
            d_beats_reg  <= beats_next;
            d_cells_reg  <= c_cells_reg;
            d_meta_reg   <= c_meta_reg;
            e_rank_reg   <= rank_next;
            e_cells_reg  <= d_cells_reg;
            e_meta_reg   <= d_meta_reg;
            o_median_reg <= median_next;
            o_meta_reg   <= e_meta_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_median = o_median_reg;
    assign out_meta   = o_meta_reg;

    a_one_median : assert property (@(posedge aclk) disable iff (!aresetn)
        e_valid_reg |-> $onehot(hit))
        else $error("median rank not unique");

    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && o_valid_reg) |=> (o_valid_reg && $stable(o_median_reg)))
        else $error("output stage changed while stalled");

    a_drain_order : assert property (@(posedge aclk) disable iff (!aresetn)
        (en && e_valid_reg) |=> o_valid_reg)
        else $error("result lost between rank and output stage");

endmodule

`default_nettype wire

### hdl/median_window_filter.sv
// Top level of the streaming 2-D median window filter.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tdata: pixel; tuser: req_type (1 = drain tick)
//  m_      | out | m_tvalid/m_tready  | tdata: median_value, out_col, out_row; tlast: last_pixel
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One transaction per cycle unless stalled; the line store's one write port and registered read
// set it. The b, c, d, e, o stages carry a window-completing transaction or fetch to m_tvalid.
// Images with fewer pixels than the window lag: after the last pixel, s_tready drops
// for one catch-up column read per cycle, while the m_ side accepts, until the window is aligned.
// aresetn is synchronous; the line store is not cleared. A full m_ side stalls all stages.
`default_nettype none

module median_window_filter
    import mwf_pkg::*;
#(
    parameter int MAX_WIDTH        = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT       = DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW_CELLS = DEF_MAX_WINDOW_CELLS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
    input  wire logic                  s_tuser,   // [0] req_type
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,   // [7:0] median_value, [17:8] out_col,
                                                  // [27:18] out_row, [31:28] zero
    output logic                       m_tlast,   // last_pixel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WBW      = $clog2(MAX_WIDTH + 1);
    localparam int CAW      = $clog2(MAX_WIDTH);
    localparam int HBW      = $clog2(MAX_HEIGHT + 1);
    localparam int RW       = $clog2(MAX_HEIGHT + 4);
    localparam int GW       = $clog2(2 * MAX_WIDTH + 4);
    localparam int SIDE_CAP = (MAX_WINDOW_CELLS >= 25) ? 5 : ((MAX_WINDOW_CELLS >= 9) ? 3 : 1);

    logic [2:0]            win_size_reg;
    logic [CFG_DATA_W-1:0] img_width_reg, img_height_reg;

    logic [WBW-1:0] w_eff;
    logic [HBW-1:0] ht_eff;
    logic [RW-1:0]  ht_r;
    logic [2:0]     side;
    logic [1:0]     half;
    logic [GW-1:0]  lag, lag_p1;

    logic [CAW-1:0] in_col_reg, in_col_next, emit_col_reg, emit_col_next, f_col_reg, f_col_next;
    logic [RW-1:0]  in_row_reg, in_row_next, emit_row_reg, emit_row_next, f_row_reg, f_row_next;
    logic [GW-1:0]  fgap_reg, fgap_next, fgap_wr, fgap_sh;
    logic           pend_reg, pend_next;

    logic adv, accept_in, wr, ready_item, want, shift, emit, frame_end, cfg_we;

    logic [WIN_SIDE-1:0] col_ok, row_ok;
    logic                last_a;
    fetch_ctl_t          fetch_ctl;

    logic                b_valid_reg, b_emit_reg;
    logic [WIN_SIDE-1:0] b_col_ok_reg;
    out_meta_t           b_meta_reg, o_meta;
    col_t                fetched;
    col_t [WIN_SIDE-1:0] window_reg, window_next;
    cells_t              cells;
    pix_t                o_median;
    logic                o_valid;

    // Effective configuration.
    always_comb begin
        if (img_width_reg == '0) begin
            w_eff = WBW'(1);
        end else if (int'(img_width_reg) > MAX_WIDTH) begin
            w_eff = WBW'(MAX_WIDTH);
        end else begin
            w_eff = WBW'(img_width_reg);
        end
        if (img_height_reg == '0) begin
            ht_eff = HBW'(1);
        end else if (int'(img_height_reg) > MAX_HEIGHT) begin
            ht_eff = HBW'(MAX_HEIGHT);
        end else begin
            ht_eff = HBW'(img_height_reg);
        end
        ht_r = RW'(ht_eff);
        side = win_size_reg;
        if (side == 3'd0) begin
            side = 3'd1;
        end
        if (!side[0]) begin
            side = side - 3'd1;
        end
        if (int'(side) > SIDE_CAP) begin
            side = 3'(SIDE_CAP);
        end
        half = side[2:1];
        unique case (half)
            2'd0:    lag = '0;
            2'd1:    lag = GW'(w_eff) + GW'(1);
            2'd2:    lag = (GW'(w_eff) << 1) + GW'(2);
            default: lag = '0;
        endcase
        lag_p1 = lag + GW'(1);
    end

    assign adv       = !o_valid || m_tready;
    assign s_tready  = adv && !pend_reg;
    assign accept_in = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready && (cfg_index == CFG_WINDOW_SIZE ||
                       cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

    // Position bookkeeping for one transaction or one catch-up fetch.
    always_comb begin
        wr = accept_in && !s_tuser && (in_row_reg < ht_r);
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        if (wr) begin
            if (WBW'(in_col_reg) + WBW'(1) >= w_eff) begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end else begin
                in_col_next = in_col_reg + CAW'(1);
            end
        end
        fgap_wr    = fgap_reg + GW'(wr);
        ready_item = accept_in && (emit_row_reg < ht_r) &&
                     ((in_row_next >= ht_r) || (fgap_wr > lag));
        want       = ready_item || (pend_reg && adv);
        shift      = wr || want;
        fgap_sh    = fgap_reg + GW'(shift);
        emit       = want && (fgap_sh == lag_p1);
        fgap_next  = fgap_sh - GW'(emit);
        pend_next  = want ? !emit : pend_reg;

        f_col_next = f_col_reg;
        f_row_next = f_row_reg;
        if (shift) begin
            if (WBW'(f_col_reg) + WBW'(1) >= w_eff) begin
                f_col_next = '0;
                f_row_next = f_row_reg + RW'(1);
            end else begin
                f_col_next = f_col_reg + CAW'(1);
            end
        end

        emit_col_next = emit_col_reg;
        emit_row_next = emit_row_reg;
        if (emit) begin
            if (WBW'(emit_col_reg) + WBW'(1) >= w_eff) begin
                emit_col_next = '0;
                emit_row_next = emit_row_reg + RW'(1);
            end else begin
                emit_col_next = emit_col_reg + CAW'(1);
            end
        end
        frame_end = emit && (emit_row_next >= ht_r);
    end

    // Masks for the fetched column rows and the window columns.
    always_comb begin
        int rr;
        int cp;
        cp = int'(emit_col_reg) + int'(half);
        for (int k = 0; k < WIN_SIDE; k++) begin
            rr        = int'(f_row_reg) + k - (WIN_SIDE - 1);
            row_ok[k] = (rr >= 0) && (rr < int'(ht_eff));
            col_ok[k] = (cp - k >= 0) && (cp - k < int'(w_eff));
        end
        last_a = (int'(emit_col_reg) == int'(w_eff) - 1) &&
                 (int'(emit_row_reg) == int'(ht_eff) - 1);
        fetch_ctl.base_lane = f_row_reg[LANE_W-1:0] + LANE_W'(LANES - (WIN_SIDE - 1));
        fetch_ctl.row_ok    = row_ok;
        fetch_ctl.pix       = wr ? s_tdata : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_size_reg   <= 3'd3;
            img_width_reg  <= CFG_DATA_W'(1024);
            img_height_reg <= CFG_DATA_W'(1024);
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            emit_col_reg   <= '0;
            emit_row_reg   <= '0;
            f_col_reg      <= '0;
            f_row_reg      <= '0;
            fgap_reg       <= '0;
            pend_reg       <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WINDOW_SIZE:  win_size_reg   <= cfg_data[2:0];
                CFG_IMAGE_WIDTH:  img_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: img_height_reg <= cfg_data;
                default:          win_size_reg   <= win_size_reg;
            endcase
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
            f_col_reg    <= '0;
            f_row_reg    <= '0;
            fgap_reg     <= '0;
            pend_reg     <= 1'b0;
        end else if (frame_end) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
            f_col_reg    <= '0;
            f_row_reg    <= '0;
            fgap_reg     <= '0;
            pend_reg     <= 1'b0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            emit_col_reg <= emit_col_next;
            emit_row_reg <= emit_row_next;
            f_col_reg    <= f_col_next;
            f_row_reg    <= f_row_next;
            fgap_reg     <= fgap_next;
            pend_reg     <= pend_next;
        end
    end

    mwf_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (wr),
        .wr_lane (in_row_reg[LANE_W-1:0]),
        .wr_addr (in_col_reg),
        .wr_pix  (s_tdata),
        .rd_en   (shift),
        .rd_addr (f_col_reg),
        .rd_ctl  (fetch_ctl),
        .rd_col  (fetched)
    );

    // Column fetch stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            b_emit_reg  <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= shift;
            b_emit_reg  <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_col_ok_reg    <= col_ok;
            b_meta_reg.last <= last_a;
            b_meta_reg.row  <= POS_W'(emit_row_reg);
            b_meta_reg.col  <= POS_W'(emit_col_reg);
            if (b_valid_reg) begin
                window_reg <= window_next;
            end
        end
    end

    // Window columns, newest first; unused cells get filler.
    always_comb begin
        logic used;
        window_next[0] = fetched;
        for (int d = 1; d < WIN_SIDE; d++) begin
            window_next[d] = window_reg[d-1];
        end
        for (int d = 0; d < WIN_SIDE; d++) begin
            for (int k = 0; k < WIN_SIDE; k++) begin
                used = (d < int'(side)) && (k >= WIN_SIDE - int'(side));
                if (!used) begin
                    cells[d*WIN_SIDE + k] = pad_value(d, k);
                end else if (b_col_ok_reg[d]) begin
                    cells[d*WIN_SIDE + k] = window_next[d][k];
                end else begin
                    cells[d*WIN_SIDE + k] = '0;
                end
            end
        end
    end

    mwf_rank_median u_rank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (b_valid_reg && b_emit_reg),
        .in_cells   (cells),
        .in_meta    (b_meta_reg),
        .out_valid  (o_valid),
        .out_median (o_median),
        .out_meta   (o_meta)
    );

    assign m_tvalid = o_valid;
    assign m_tdata  = {{(M_DATA_W - PIX_W - 2*POS_W){1'b0}}, o_meta.row, o_meta.col, o_median};
    assign m_tlast  = o_meta.last;

    a_gap_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        fgap_reg <= lag_p1)
        else $error("fetch position ran ahead of the window");

    a_catchup_after_image : assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (in_row_reg >= ht_r))
        else $error("catch-up fetch before the image is complete");

    a_emit_in_frame : assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (emit_row_reg < ht_r) && shift)
        else $error("result issued outside the frame");

    a_cfg_restart : assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> (fgap_reg == '0) && !pend_reg && (f_col_reg == '0))
        else $error("configuration write did not restart the frame");

endmodule

`default_nettype wire
